// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL that checks itself.
// Every check is sampled on the rising edge of clk and is off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/qee_pkg.sv
`default_nettype none

package qee_pkg;

	// Number of wait table entries in use; the index saturates at the last entry.
	localparam int TABLE_ENTRIES = 40;
	localparam int ROM_SLOTS     = 64;
	localparam int IDX_W         = $clog2(ROM_SLOTS);

	// A stored wait equal to this value marks the deadband: all outputs are held low.
	localparam logic [7:0] DEADB = 8'd47;

	// A sample index at or above this value selects forward motion.
	localparam logic [IDX_W-1:0] FWD_IDX_MIN = IDX_W'(20);
	localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(TABLE_ENTRIES - 1);

	// The blink period is (BLINK_BASE - wait) / 10.
	localparam logic [7:0] BLINK_BASE = 8'd201;

	// sample / 100 equals (sample * 5243) >> 19 for every 12-bit sample.
	localparam int DIV100_MUL   = 5243;
	localparam int DIV100_SHIFT = 19;
	localparam int DIV100_W     = 25;

	// x / 10 equals (x * 205) >> 11 for every x up to 201.
	localparam int DIV10_MUL   = 205;
	localparam int DIV10_SHIFT = 11;
	localparam int DIV10_W     = 16;

	typedef struct packed {
		logic [11:0] adc_sample;
		logic        adc_ok;
	} sample_t;

	typedef struct packed {
		logic       pin_a;
		logic       pin_b;
		logic       red_led;
		logic       green_led;
		logic [7:0] wait_ms;
	} result_t;

	// Wait table in milliseconds, indexed by the clamped sample index.
	function automatic logic [7:0] wait_rom(input logic [IDX_W-1:0] idx);
		logic [7:0] w;
		case (idx)
			6'd0, 6'd1:                   w = 8'd0;
			6'd2, 6'd3:                   w = 8'd2;
			6'd4:                         w = 8'd4;
			6'd5:                         w = 8'd6;
			6'd6:                         w = 8'd8;
			6'd7:                         w = 8'd10;
			6'd8:                         w = 8'd20;
			6'd9:                         w = 8'd30;
			6'd10:                        w = 8'd40;
			6'd11:                        w = 8'd50;
			6'd12:                        w = 8'd60;
			6'd13:                        w = 8'd70;
			6'd14:                        w = 8'd80;
			6'd15:                        w = 8'd90;
			6'd16:                        w = 8'd100;
			6'd17:                        w = 8'd200;
			6'd18, 6'd19, 6'd20, 6'd21:   w = DEADB;
			6'd22:                        w = 8'd200;
			6'd23:                        w = 8'd100;
			6'd24:                        w = 8'd90;
			6'd25:                        w = 8'd80;
			6'd26:                        w = 8'd70;
			6'd27:                        w = 8'd60;
			6'd28:                        w = 8'd50;
			6'd29:                        w = 8'd40;
			6'd30:                        w = 8'd30;
			6'd31:                        w = 8'd20;
			6'd32:                        w = 8'd10;
			6'd33:                        w = 8'd8;
			6'd34:                        w = 8'd6;
			6'd35:                        w = 8'd4;
			6'd36, 6'd37:                 w = 8'd2;
			default:                      w = 8'd0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/quadrature_encoder_emulator_core.sv
// Channel   Direction  Handshake                     Payload
// sample    in         sample_valid / sample_stall   qee_pkg::sample_t (adc_sample, adc_ok)
// result    out        result_valid / result_stall   qee_pkg::result_t (pins, LEDs, wait_ms)
//
// One sample transfer yields exactly one result transfer, in order.
// Throughput is one item per cycle while result_stall is low; each sample passes through the
// input register, and its result is written to the result register and leaves from there.
// arst_n clears phase, direction, blink count, stored wait, output levels and both valids.
// A stall on the result side holds the result register; the input register still takes
// one more item, and sample_stall rises only while both registers are full.
`default_nettype none
`include "assert_macros.svh"

module quadrature_encoder_emulator_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              sample_valid,
	output      logic              sample_stall,
	input  wire qee_pkg::sample_t  sample,
	output      logic              result_valid,
	input  wire logic              result_stall,
	output      qee_pkg::result_t  result
);

	// Input register.
	logic              valid_s1;
	qee_pkg::sample_t  sample_s1;

	// Result register.
	logic              res_valid_q;
	qee_pkg::result_t  res_q;

	// Generator state, updated each time an item leaves the input register.
	logic [1:0]  phase_q;
	logic        reverse_q;
	logic [4:0]  blink_q;
	logic [7:0]  wait_q;
	logic [3:0]  levels_q;   // bit 0 A, bit 1 B, bit 2 red, bit 3 green

	logic        advance;
	logic [3:0]  levels_next;
	logic [1:0]  phase_next;
	logic [4:0]  blink_next;
	logic [4:0]  blink_inc;
	logic [4:0]  period;
	logic [7:0]  period_num;
	logic [qee_pkg::DIV10_W-1:0]  period_prod;
	logic [qee_pkg::DIV100_W-1:0] idx_prod;
	logic [qee_pkg::IDX_W-1:0]    idx_raw;
	logic [qee_pkg::IDX_W-1:0]    idx;
	logic        reverse_next;
	logic [7:0]  wait_next;
	logic        a, b, red, green;

	// The input register moves on whenever the result register is empty or is being drained.
	assign advance      = valid_s1 && (!res_valid_q || !result_stall);
	assign sample_stall = valid_s1 && !advance;

	// The blink period depends on the wait stored by the previous item. A wait above the
	// base would give a zero period; the table never produces one, but it is handled.
	assign period_num  = (wait_q <= qee_pkg::BLINK_BASE) ? (qee_pkg::BLINK_BASE - wait_q) : 8'd0;
	assign period_prod = qee_pkg::DIV10_W'(period_num) * qee_pkg::DIV10_W'(qee_pkg::DIV10_MUL);
	assign period      = period_prod[qee_pkg::DIV10_SHIFT +: 5];
	assign blink_inc   = blink_q + 5'd1;

	// Phase step and LED blink act on the stored wait and direction.
	always_comb begin
		a          = levels_q[0];
		b          = levels_q[1];
		red        = levels_q[2];
		green      = levels_q[3];
		phase_next = phase_q;
		blink_next = blink_q;
		if (wait_q != qee_pkg::DEADB) begin
			case (phase_q)
				2'd0: begin
					a = 1'b0;
					b = 1'b0;
				end
				2'd1: begin
					if (reverse_q) a = 1'b1;
					else b = 1'b1;
				end
				2'd2: begin
					if (reverse_q) b = 1'b1;
					else a = 1'b1;
				end
				default: begin
					if (reverse_q) a = 1'b0;
					else b = 1'b0;
				end
			endcase
			phase_next = phase_q + 2'd1;
			blink_next = blink_inc;
			if (blink_inc >= period) begin
				if (reverse_q) begin
					red   = !red;
					green = 1'b0;
				end else begin
					green = !green;
					red   = 1'b0;
				end
				blink_next = 5'd0;
			end
		end else begin
			// Deadband: everything low, phase and blink count kept.
			a     = 1'b0;
			b     = 1'b0;
			red   = 1'b0;
			green = 1'b0;
		end
		levels_next = {green, red, b, a};
	end

	// The new sample picks the direction and the next wait. A failed conversion reads as
	// index zero, which is reverse.
	assign idx_prod = qee_pkg::DIV100_W'(sample_s1.adc_sample)
		* qee_pkg::DIV100_W'(qee_pkg::DIV100_MUL);
	assign idx_raw  = sample_s1.adc_ok ? idx_prod[qee_pkg::DIV100_SHIFT +: qee_pkg::IDX_W]
		: '0;
	assign reverse_next = !(idx_raw >= qee_pkg::FWD_IDX_MIN);
	assign idx          = (idx_raw > qee_pkg::LAST_IDX) ? qee_pkg::LAST_IDX : idx_raw;
	assign wait_next    = qee_pkg::wait_rom(idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			phase_q     <= '0;
			reverse_q   <= 1'b0;
			blink_q     <= '0;
			wait_q      <= '0;
			levels_q    <= '0;
		end else begin
			if (!sample_stall) valid_s1 <= sample_valid;
			if (advance) begin
				res_valid_q <= 1'b1;
				phase_q     <= phase_next;
				reverse_q   <= reverse_next;
				blink_q     <= blink_next;
				wait_q      <= wait_next;
				levels_q    <= levels_next;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (!sample_stall && sample_valid) sample_s1 <= sample;
		if (advance) begin
			res_q.pin_a     <= levels_next[0];
			res_q.pin_b     <= levels_next[1];
			res_q.red_led   <= levels_next[2];
			res_q.green_led <= levels_next[3];
			res_q.wait_ms   <= wait_next;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	`ASSERT_NEXT(a_deadband_low, advance && (wait_q == qee_pkg::DEADB), levels_q == 4'd0,
		"deadband step did not drive all outputs low")
	`ASSERT_NEXT(a_phase_step, advance && (wait_q != qee_pkg::DEADB),
		phase_q == $past(phase_q) + 2'd1, "phase did not advance on an active step")
	`ASSERT_ALWAYS(a_one_led, !(levels_q[2] && levels_q[3]), "both direction LEDs lit")
	`ASSERT_ALWAYS(a_wait_range, wait_q <= 8'd200, "stored wait outside the table range")

endmodule

`default_nettype wire
